/* rtl/psme_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psme_pkg
// Shared sizes, operation codes, word types and fixed-point helpers for the
// PCA shape model engine.
// ----------------------------------------------------------------------------
package psme_pkg;

	localparam int NUM_VERTICES   = 1024;
	localparam int NUM_COMPONENTS = 16;
	localparam int NCOORD         = 3 * NUM_VERTICES;
	localparam int MAX_RESULTS    = 16;
	localparam int NUM_PROJ       = (NUM_COMPONENTS < MAX_RESULTS) ? NUM_COMPONENTS
	                                                               : MAX_RESULTS;
	localparam int AW             = $clog2(NCOORD);
	localparam int CW             = $clog2(NUM_COMPONENTS);
	localparam int BDEPTH         = NUM_COMPONENTS * NCOORD;
	localparam int BAW            = $clog2(BDEPTH);
	localparam int DIV_STEPS      = 33;
	localparam int DCW            = $clog2(DIV_STEPS);

	localparam logic [3:0] OP_MEAN        = 4'd0;
	localparam logic [3:0] OP_COORD       = 4'd1;
	localparam logic [3:0] OP_BASIS       = 4'd2;
	localparam logic [3:0] OP_STDDEV      = 4'd3;
	localparam logic [3:0] OP_SET_PARAM   = 4'd4;
	localparam logic [3:0] OP_STAGE_PARAM = 4'd5;
	localparam logic [3:0] OP_REBUILD     = 4'd6;
	localparam logic [3:0] OP_TO_MEAN     = 4'd7;
	localparam logic [3:0] OP_PROJECT     = 4'd8;
	localparam logic [3:0] OP_READ        = 4'd9;

	typedef struct packed {
		logic [3:0]          operation;
		logic [11:0]         coord_index;
		logic [3:0]          component;
		logic signed [31:0]  value;
	} item_t;

	typedef struct packed {
		logic signed [31:0]  result_value;
		logic [3:0]          result_component;
		logic                saturated;
		logic                last;
	} result_t;

	// q15.16 product, round half up
	function automatic logic signed [47:0] mulq(input logic signed [31:0] a,
	                                            input logic signed [31:0] b);
		logic signed [63:0] p;
		p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
		p = p + 64'sd32768;
		return p[63:16];
	endfunction

	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > 64'sh0000_0000_7FFF_FFFF) || (v < -64'sh0000_0000_8000_0000);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/psme_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// psme_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module psme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/pca_shape_model_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pca_shape_model_engine
// Linear PCA shape model: mean, basis, deviations, parameters and current
// shape, with incremental update, rebuild, return to mean, projection, read.
// ----------------------------------------------------------------------------
// One item is taken at a time; item_ready is high only while the engine is
// idle, and a finished result may still wait in the output register while the
// next item is taken. All element work runs through one 32x32 multiplier fed
// by the basis memory's single read port, one product per cycle. Projection
// takes, for each of the 16 components, a dot product over the coordinates, a
// drain, a divide set-up, a bit-serial divide, a finish and an emit, after the
// take and decode steps; a component with zero deviation skips the divide and
// finish. A stalled receiver holds the engine in its emit step. The stores
// need no clearing pass; the parameters clear at reset.
// ----------------------------------------------------------------------------
module pca_shape_model_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  psme_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output psme_pkg::result_t result
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_EXEC   = 9'b000000010,
		S_PREP   = 9'b000000100,
		S_STREAM = 9'b000001000,
		S_DRAIN  = 9'b000010000,
		S_DIVSET = 9'b000100000,
		S_DIV    = 9'b001000000,
		S_DIVEND = 9'b010000000,
		S_EMIT   = 9'b100000000
	} state_t;

	localparam int NC = psme_pkg::NUM_COMPONENTS;
	localparam int CW = psme_pkg::CW;
	localparam int AW = psme_pkg::AW;
	localparam int DCW_W = psme_pkg::DCW;

	state_t state_q;

	logic [3:0]         op_q;
	logic [11:0]        ci_q;
	logic [3:0]         c_q;
	logic signed [31:0] val_q;
	logic               flag_q;

	logic signed [31:0] param_q [NC];
	logic signed [31:0] dev_q   [NC];
	logic signed [31:0] sp_q    [NC];
	logic signed [31:0] diff_q;

	logic [AW-1:0]      i_q;
	logic [CW-1:0]      j_q;
	logic [CW-1:0]      pc_q;
	logic [CW:0]        prep_q;

	logic               v_s1, first_s1, last_s1;
	logic [AW-1:0]      i_s1;
	logic [CW-1:0]      j_s1;
	logic               v_s2, first_s2, last_s2;
	logic [AW-1:0]      i_s2;
	logic signed [47:0] prod_s2;
	logic signed [31:0] base_s2;
	logic signed [63:0] acc_q;

	logic [63:0]        num_q;
	logic [31:0]        rem_q;
	logic [32:0]        quot_q;
	logic [31:0]        us_q;
	logic               neg_q, big_q;
	logic [DCW_W-1:0]   div_cnt_q;
	logic signed [31:0] res_q;

	psme_pkg::result_t  out_q;
	logic               out_valid_q;

	// ---- decode ----
	logic          ci_ok, c_ok;
	logic [CW-1:0] c_idx;
	logic [AW-1:0] ci_addr;

	assign ci_ok   = {20'd0, ci_q} < 32'(psme_pkg::NCOORD);
	assign c_ok    = {28'd0, c_q} < 32'(NC);
	assign c_idx   = c_q[CW-1:0];
	assign ci_addr = ci_q[AW-1:0];

	// ---- memories ----
	logic                     mean_we, shape_we, basis_we, stream_re, shape_re;
	logic [AW-1:0]            shape_waddr, shape_raddr;
	logic signed [31:0]       shape_wdata;
	logic [psme_pkg::BAW-1:0] basis_waddr, basis_raddr;
	logic signed [31:0]       mean_rd, shape_rd, basis_rd;

	assign stream_re   = (state_q == S_STREAM);
	assign shape_re    = stream_re || (state_q == S_EXEC);
	assign shape_raddr = (state_q == S_EXEC) ? ci_addr : i_q;
	assign mean_we     = (state_q == S_EXEC) && (op_q == psme_pkg::OP_MEAN) && ci_ok;
	assign basis_we    = (state_q == S_EXEC) && (op_q == psme_pkg::OP_BASIS) && ci_ok && c_ok;
	assign basis_waddr = psme_pkg::BAW'(c_idx) * psme_pkg::BAW'(psme_pkg::NCOORD)
	                   + psme_pkg::BAW'(ci_addr);
	assign basis_raddr = psme_pkg::BAW'(j_q) * psme_pkg::BAW'(psme_pkg::NCOORD)
	                   + psme_pkg::BAW'(i_q);

	psme_ram #(.WIDTH(32), .DEPTH(psme_pkg::NCOORD)) u_mean (
		.clk(clk), .we(mean_we), .waddr(ci_addr), .wdata(val_q),
		.re(stream_re), .raddr(i_q), .rdata(mean_rd)
	);

	psme_ram #(.WIDTH(32), .DEPTH(psme_pkg::NCOORD)) u_shape (
		.clk(clk), .we(shape_we), .waddr(shape_waddr), .wdata(shape_wdata),
		.re(shape_re), .raddr(shape_raddr), .rdata(shape_rd)
	);

	psme_ram #(.WIDTH(32), .DEPTH(psme_pkg::BDEPTH)) u_basis (
		.clk(clk), .we(basis_we), .waddr(basis_waddr), .wdata(val_q),
		.re(stream_re), .raddr(basis_raddr), .rdata(basis_rd)
	);

	// ---- set-up products ----
	logic               is_prep;
	logic [CW:0]        prep_n;
	logic [CW-1:0]      prep_idx, prev_idx;
	logic signed [63:0] d_full;
	logic signed [31:0] d_sat;
	logic signed [31:0] prep_b;

	assign is_prep  = (state_q == S_PREP);
	assign prep_n   = (op_q == psme_pkg::OP_SET_PARAM) ? (CW+1)'(1) : (CW+1)'(NC);
	assign prep_idx = (op_q == psme_pkg::OP_SET_PARAM) ? c_idx : prep_q[CW-1:0];
	assign prev_idx = CW'(prep_q - 1'b1);
	assign d_full   = 64'(val_q) - 64'(param_q[c_idx]);
	assign d_sat    = psme_pkg::sat32(d_full);
	assign prep_b   = (op_q == psme_pkg::OP_SET_PARAM) ? d_sat : param_q[prep_idx];

	// ---- stage 1: operand select ----
	logic signed [63:0] v_full;
	logic signed [31:0] opnd_s1, base_s1;
	logic signed [31:0] mul_a, mul_b;
	logic               vflag_s1;

	assign v_full = 64'(shape_rd) - 64'(mean_rd);

	always_comb begin
		case (op_q)
			psme_pkg::OP_SET_PARAM: opnd_s1 = diff_q;
			psme_pkg::OP_REBUILD:   opnd_s1 = sp_q[j_s1];
			psme_pkg::OP_PROJECT:   opnd_s1 = psme_pkg::sat32(v_full);
			default:                opnd_s1 = '0;
		endcase
	end

	assign base_s1  = (op_q == psme_pkg::OP_SET_PARAM) ? shape_rd : mean_rd;
	assign vflag_s1 = v_s1 && (op_q == psme_pkg::OP_PROJECT) && psme_pkg::ovf32(v_full);
	assign mul_a    = is_prep ? dev_q[prep_idx] : basis_rd;
	assign mul_b    = is_prep ? prep_b : opnd_s1;

	// ---- stage 3: accumulate and write back ----
	logic signed [63:0] acc_in, sum;
	logic               wb_ovf;

	assign acc_in = !first_s2 ? acc_q
	              : ((op_q == psme_pkg::OP_PROJECT) ? 64'sd0 : 64'(base_s2));
	assign sum    = acc_in + 64'(prod_s2);
	assign wb_ovf = v_s2 && last_s2 && (op_q != psme_pkg::OP_PROJECT) && psme_pkg::ovf32(sum);

	always_comb begin
		if (state_q == S_EXEC) begin
			shape_we    = (op_q == psme_pkg::OP_COORD) && ci_ok;
			shape_waddr = ci_addr;
			shape_wdata = val_q;
		end else begin
			shape_we    = v_s2 && last_s2 && (op_q != psme_pkg::OP_PROJECT);
			shape_waddr = i_s2;
			shape_wdata = psme_pkg::sat32(sum);
		end
	end

	// ---- issue tags ----
	logic iss_first, iss_last, iss_done, i_end, j_end;

	assign i_end = (i_q == AW'(psme_pkg::NCOORD - 1));
	assign j_end = (j_q == CW'(NC - 1));

	always_comb begin
		if (op_q == psme_pkg::OP_REBUILD) begin
			iss_first = (j_q == '0);
			iss_last  = j_end;
			iss_done  = i_end && j_end;
		end else if (op_q == psme_pkg::OP_PROJECT) begin
			iss_first = (i_q == '0);
			iss_last  = i_end;
			iss_done  = i_end;
		end else begin
			iss_first = 1'b1;
			iss_last  = 1'b1;
			iss_done  = i_end;
		end
	end

	// ---- divide set-up and finish ----
	logic signed [31:0] sd;
	logic [63:0]        ua, num_init;
	logic [32:0]        us33;
	logic [32:0]        div_t, div_sub;
	logic               div_ge;
	logic [33:0]        mag;
	logic signed [63:0] coef;

	assign sd       = dev_q[pc_q];
	assign ua       = acc_q[63] ? (64'd0 - acc_q) : acc_q;
	assign us33     = sd[31] ? (33'd0 - {sd[31], sd}) : {1'b0, sd};
	assign num_init = (ua << 16) + 64'(us33[31:1]);
	assign div_t    = {rem_q, num_q[32]};
	assign div_sub  = div_t - {1'b0, us_q};
	assign div_ge   = div_t >= {1'b0, us_q};
	assign mag      = big_q ? 34'h2_0000_0000 : {1'b0, quot_q};
	assign coef     = neg_q ? (64'sd0 - 64'(mag)) : 64'(mag);

	// ---- result word ----
	logic              emit_go, more_proj;
	psme_pkg::result_t emit_word;

	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || result_ready);
	assign more_proj = (op_q == psme_pkg::OP_PROJECT) && (pc_q != CW'(psme_pkg::NUM_PROJ - 1));

	always_comb begin
		emit_word.result_component = '0;
		emit_word.saturated        = flag_q;
		emit_word.last             = !more_proj;
		if (op_q == psme_pkg::OP_PROJECT) begin
			emit_word.result_value     = res_q;
			emit_word.result_component = 4'(pc_q);
		end else if ((op_q == psme_pkg::OP_READ) && ci_ok) begin
			emit_word.result_value = shape_rd;
		end else begin
			emit_word.result_value = '0;
		end
	end

	// ---- control ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			flag_q      <= 1'b0;
			prep_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			pc_q        <= '0;
			div_cnt_q   <= '0;
			for (int k = 0; k < NC; k++) begin
				param_q[k] <= '0;
			end
		end else begin
			v_s1 <= stream_re;
			v_s2 <= v_s1;
			if (vflag_s1 || wb_ovf) begin
				flag_q <= 1'b1;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						flag_q  <= 1'b0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					i_q    <= '0;
					j_q    <= (op_q == psme_pkg::OP_SET_PARAM) ? c_idx : '0;
					pc_q   <= '0;
					prep_q <= '0;
					case (op_q)
						psme_pkg::OP_STAGE_PARAM: begin
							if (c_ok) begin
								param_q[c_idx] <= val_q;
							end
							state_q <= S_EMIT;
						end
						psme_pkg::OP_SET_PARAM: begin
							state_q <= c_ok ? S_PREP : S_EMIT;
						end
						psme_pkg::OP_REBUILD: begin
							state_q <= S_PREP;
						end
						psme_pkg::OP_TO_MEAN: begin
							for (int k = 0; k < NC; k++) begin
								param_q[k] <= '0;
							end
							state_q <= S_STREAM;
						end
						psme_pkg::OP_PROJECT: begin
							state_q <= S_STREAM;
						end
						default: begin
							state_q <= S_EMIT;
						end
					endcase
				end
				S_PREP: begin
					prep_q <= prep_q + 1'b1;
					if ((prep_q == '0) && (op_q == psme_pkg::OP_SET_PARAM) && psme_pkg::ovf32(d_full))
					begin
						flag_q <= 1'b1;
					end
					if ((prep_q != '0) && psme_pkg::ovf32(64'(prod_s2))) begin
						flag_q <= 1'b1;
					end
					if (prep_q == prep_n) begin
						if (op_q == psme_pkg::OP_SET_PARAM) begin
							param_q[c_idx] <= val_q;
						end
						state_q <= S_STREAM;
					end
				end
				S_STREAM: begin
					if ((op_q == psme_pkg::OP_REBUILD) && !j_end) begin
						j_q <= j_q + 1'b1;
					end else begin
						if (op_q == psme_pkg::OP_REBUILD) begin
							j_q <= '0;
						end
						i_q <= i_q + 1'b1;
					end
					if (iss_done) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= (op_q == psme_pkg::OP_PROJECT) ? S_DIVSET : S_EMIT;
					end
				end
				S_DIVSET: begin
					div_cnt_q <= '0;
					if (sd == '0) begin
						flag_q  <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCW_W'(psme_pkg::DIV_STEPS - 1)) begin
						state_q <= S_DIVEND;
					end
				end
				S_DIVEND: begin
					if (psme_pkg::ovf32(coef)) begin
						flag_q <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						if (more_proj) begin
							pc_q    <= pc_q + 1'b1;
							j_q     <= pc_q + 1'b1;
							i_q     <= '0;
							flag_q  <= 1'b0;
							state_q <= S_STREAM;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && item_valid) begin
			op_q  <= item.operation;
			ci_q  <= item.coord_index;
			c_q   <= item.component;
			val_q <= item.value;
		end
		if ((state_q == S_EXEC) && (op_q == psme_pkg::OP_STDDEV) && c_ok) begin
			dev_q[c_idx] <= val_q;
		end
		if (is_prep && (prep_q != '0)) begin
			if (op_q == psme_pkg::OP_SET_PARAM) begin
				diff_q <= psme_pkg::sat32(64'(prod_s2));
			end else begin
				sp_q[prev_idx] <= psme_pkg::sat32(64'(prod_s2));
			end
		end

		first_s1 <= iss_first;
		last_s1  <= iss_last;
		i_s1     <= i_q;
		j_s1     <= j_q;

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		i_s2     <= i_s1;
		base_s2  <= base_s1;
		prod_s2  <= ((op_q == psme_pkg::OP_TO_MEAN) && !is_prep) ? 48'sd0
		          : psme_pkg::mulq(mul_a, mul_b);
		if (v_s2) begin
			acc_q <= sum;
		end

		if (state_q == S_DIVSET) begin
			num_q  <= num_init;
			rem_q  <= {1'b0, num_init[63:33]};
			quot_q <= '0;
			us_q   <= us33[31:0];
			neg_q  <= acc_q[63] ^ sd[31];
			big_q  <= ua >= {16'd0, us33[31:0], 16'd0};
			if (sd == '0) begin
				res_q <= (acc_q > 64'sd0) ? 32'sh7FFF_FFFF
				       : ((acc_q < 64'sd0) ? 32'sh8000_0000 : 32'sd0);
			end
		end
		if (state_q == S_DIV) begin
			num_q  <= num_q << 1;
			rem_q  <= div_ge ? div_sub[31:0] : div_t[31:0];
			quot_q <= {quot_q[31:0], div_ge};
		end
		if (state_q == S_DIVEND) begin
			res_q <= psme_pkg::sat32(coef);
		end
		if (emit_go) begin
			out_q <= emit_word;
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// ---- assertions ----
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> (!v_s1 && !v_s2))
		else $error("element pipeline busy while idle");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (us_q != '0))
		else $error("divide running on zero divisor");

	a_shape_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		shape_we |-> ((state_q == S_EXEC) || (state_q == S_STREAM) || (state_q == S_DRAIN)))
		else $error("shape write outside update");

	a_partial_only_project: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |-> (op_q == psme_pkg::OP_PROJECT))
		else $error("non-final word outside projection");

endmodule
`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PCA shape model engine. Each accepted input word
// goes through a fixed-point predictor of the model stores. Every result word
// is compared with the oldest expectation. A short table of directed words runs
// first. The stores are then filled completely, followed by the heavy
// operations and a random mix, with bursts of idling on both channels.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		psme_pkg::item_t   it;
		bit                typed;
		psme_pkg::result_t exp;
	} row_t;

	localparam psme_pkg::result_t STATUS_OK = '{32'sd0, 4'd0, 1'b0, 1'b1};
	localparam int      STALL_LIMIT = 200000;
	localparam int      MAX_HEAVY = 4;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	psme_pkg::item_t   item;
	logic              result_valid;
	logic              result_ready;
	psme_pkg::result_t result;

	// model copy of the engine stores
	int mean_m [psme_pkg::NCOORD];
	int shape_m [psme_pkg::NCOORD];
	int basis_m [psme_pkg::BDEPTH];
	int dev_m [psme_pkg::NUM_COMPONENTS];
	int param_m [psme_pkg::NUM_COMPONENTS];

	psme_pkg::result_t expected_words[$];
	psme_pkg::result_t step_words[$];
	int      mismatches;
	int      stall_cycles;
	bit      quiet;
	bit      hold_req;
	row_t    early_rows[19];
	row_t    heavy_rows[10];

	pca_shape_model_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic longint qmul(int a, int b);
		return (longint'(a) * longint'(b) + 64'sd32768) >>> 16;
	endfunction

	function automatic int clip32(longint v, inout bit f);
		if (v > 64'sh7FFF_FFFF) begin
			f = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			f = 1'b1;
			return 32'sh8000_0000;
		end
		return int'(v);
	endfunction

	// scaled coefficient of the current shape on one component
	function automatic int coefficient(int c, inout bit f);
		longint dot;
		longint unsigned ua, us, mag;
		bit neg;
		int v;
		dot = 0;
		for (int i = 0; i < psme_pkg::NCOORD; i++) begin
			v = clip32(longint'(shape_m[i]) - longint'(mean_m[i]), f);
			dot += qmul(basis_m[c * psme_pkg::NCOORD + i], v);
		end
		if (dev_m[c] == 0) begin
			f = 1'b1;
			return (dot > 0) ? 32'sh7FFF_FFFF : ((dot < 0) ? 32'sh8000_0000 : 0);
		end
		neg = (dot < 0) != (dev_m[c] < 0);
		ua = (dot < 0) ? longint'(-dot) : longint'(dot);
		us = (dev_m[c] < 0) ? -longint'(dev_m[c]) : longint'(dev_m[c]);
		if (ua >= (us << 16))
			mag = 64'd1 << 33;
		else
			mag = ((ua << 16) + us / 2) / us;
		return clip32(neg ? -longint'(mag) : longint'(mag), f);
	endfunction

	// update the model for one word and leave its results in step_words
	task automatic shape_model_step(psme_pkg::item_t it);
		psme_pkg::result_t r;
		bit f;
		int ci, c, d, diff;
		int sp [psme_pkg::NUM_COMPONENTS];
		longint acc;
		bit ci_ok, c_ok;
		step_words.delete();
		f = 1'b0;
		r = STATUS_OK;
		ci = int'(it.coord_index);
		c = int'(it.component);
		ci_ok = ci < psme_pkg::NCOORD;
		c_ok = c < psme_pkg::NUM_COMPONENTS;
		case (it.operation)
			psme_pkg::OP_MEAN: if (ci_ok) mean_m[ci] = it.value;
			psme_pkg::OP_COORD: if (ci_ok) shape_m[ci] = it.value;
			psme_pkg::OP_BASIS: if (ci_ok && c_ok) basis_m[c * psme_pkg::NCOORD + ci] = it.value;
			psme_pkg::OP_STDDEV: if (c_ok) dev_m[c] = it.value;
			psme_pkg::OP_SET_PARAM: if (c_ok) begin
				d = clip32(longint'(it.value) - longint'(param_m[c]), f);
				diff = clip32(qmul(dev_m[c], d), f);
				param_m[c] = it.value;
				for (int i = 0; i < psme_pkg::NCOORD; i++)
					shape_m[i] = clip32(longint'(shape_m[i]) +
						qmul(basis_m[c * psme_pkg::NCOORD + i], diff), f);
			end
			psme_pkg::OP_STAGE_PARAM: if (c_ok) param_m[c] = it.value;
			psme_pkg::OP_REBUILD: begin
				for (int j = 0; j < psme_pkg::NUM_COMPONENTS; j++)
					sp[j] = clip32(qmul(dev_m[j], param_m[j]), f);
				for (int i = 0; i < psme_pkg::NCOORD; i++) begin
					acc = mean_m[i];
					for (int j = 0; j < psme_pkg::NUM_COMPONENTS; j++)
						acc += qmul(basis_m[j * psme_pkg::NCOORD + i], sp[j]);
					shape_m[i] = clip32(acc, f);
				end
			end
			psme_pkg::OP_TO_MEAN: begin
				for (int j = 0; j < psme_pkg::NUM_COMPONENTS; j++)
					param_m[j] = 0;
				for (int i = 0; i < psme_pkg::NCOORD; i++)
					shape_m[i] = mean_m[i];
			end
			psme_pkg::OP_PROJECT: begin
				for (int j = 0; j < psme_pkg::NUM_PROJ; j++) begin
					f = 1'b0;
					r.result_value = coefficient(j, f);
					r.result_component = 4'(j);
					r.saturated = f;
					r.last = (j == psme_pkg::NUM_PROJ - 1);
					step_words = {step_words, r};
				end
			end
			psme_pkg::OP_READ: if (ci_ok) r.result_value = shape_m[ci];
			default: ;
		endcase
		if (it.operation != psme_pkg::OP_PROJECT) begin
			r.saturated = f;
			step_words = {step_words, r};
		end
	endtask

	// offer one word, predict once it is taken
	task automatic send_word(psme_pkg::item_t it, bit typed, psme_pkg::result_t exp);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		shape_model_step(it);
		if (typed)
			expected_words = {expected_words, exp};
		else
			expected_words = {expected_words, step_words};
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	function automatic psme_pkg::item_t mk(logic [3:0] op, int ci, int c, int v);
		psme_pkg::item_t it;
		it.operation = op;
		it.coord_index = 12'(ci);
		it.component = 4'(c);
		it.value = v;
		return it;
	endfunction

	function automatic int small_word(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// mostly modest values, now and then a full-range word
	function automatic int data_word(int span);
		if ($urandom_range(0, 15) == 0)
			return int'($urandom);
		return small_word(span);
	endfunction

	function automatic psme_pkg::item_t random_word(bit allow_heavy);
		int pick, ci;
		logic [3:0] op;
		pick = $urandom_range(0, 99);
		ci = ($urandom_range(0, 15) == 0) ? $urandom_range(psme_pkg::NCOORD, 4095)
		                                  : $urandom_range(0, psme_pkg::NCOORD - 1);
		if (pick < 12) op = psme_pkg::OP_MEAN;
		else if (pick < 26) op = psme_pkg::OP_COORD;
		else if (pick < 36) op = psme_pkg::OP_BASIS;
		else if (pick < 42) op = psme_pkg::OP_STDDEV;
		else if (pick < 52) op = psme_pkg::OP_SET_PARAM;
		else if (pick < 64) op = psme_pkg::OP_STAGE_PARAM;
		else if (pick < 68) op = allow_heavy ? psme_pkg::OP_REBUILD : psme_pkg::OP_READ;
		else if (pick < 72) op = psme_pkg::OP_TO_MEAN;
		else if (pick < 76) op = allow_heavy ? psme_pkg::OP_PROJECT : psme_pkg::OP_READ;
		else if (pick < 94) op = psme_pkg::OP_READ;
		else op = 4'($urandom_range(10, 15));
		return mk(op, ci, $urandom_range(0, 15), data_word(1 << 18));
	endfunction

	// receiver: bursts of back-pressure and one long hold-off on request
	initial begin
		result_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				$error("result word with nothing expected: value %0d", result.result_value);
			end else begin
				psme_pkg::result_t e;
				e = expected_words.pop_front();
				if (result.result_value !== e.result_value) begin
					mismatches++;
					$error("result_value expected %0d actual %0d",
						e.result_value, result.result_value);
				end
				if (result.result_component !== e.result_component) begin
					mismatches++;
					$error("result_component expected %0d actual %0d",
						e.result_component, result.result_component);
				end
				if (result.saturated !== e.saturated) begin
					mismatches++;
					$error("saturated expected %0b actual %0b", e.saturated, result.saturated);
				end
				if (result.last !== e.last) begin
					mismatches++;
					$error("last expected %0b actual %0b", e.last, result.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles == STALL_LIMIT) begin
			$display("pca_shape_model_engine regression: fail");
			$finish;
		end
	end

	initial begin
		int heavy;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		mismatches = 0;
		stall_cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		heavy = 0;
		foreach (param_m[j]) param_m[j] = 0;

		early_rows = '{
			'{mk(psme_pkg::OP_MEAN, 0, 0, 32'sh7FFF_FFFF), 1'b1, STATUS_OK},
			'{mk(psme_pkg::OP_MEAN, psme_pkg::NCOORD - 1, 0, 32'sh8000_0000), 1'b1, STATUS_OK},
			'{mk(psme_pkg::OP_COORD, 0, 0, 32'sh8000_0000), 1'b1, STATUS_OK},
			'{mk(psme_pkg::OP_COORD, psme_pkg::NCOORD - 1, 0, 32'sh7FFF_FFFF), 1'b1, STATUS_OK},
			'{mk(psme_pkg::OP_READ, 0, 0, 0), 1'b1, '{32'sh8000_0000, 4'd0, 1'b0, 1'b1}},
			'{mk(psme_pkg::OP_READ, psme_pkg::NCOORD - 1, 15, -1), 1'b1,
				'{32'sh7FFF_FFFF, 4'd0, 1'b0, 1'b1}},
			'{mk(psme_pkg::OP_READ, 4095, 0, 0), 1'b1, STATUS_OK},
			'{mk(psme_pkg::OP_COORD, 4095, 0, 1234), 1'b1, STATUS_OK},
			'{mk(psme_pkg::OP_BASIS, 5, 15, -1), 1'b1, STATUS_OK},
			'{mk(psme_pkg::OP_BASIS, psme_pkg::NCOORD, 0, 77), 1'b1, STATUS_OK},
			'{mk(psme_pkg::OP_STDDEV, 0, 15, 32'sh0001_0000), 1'b1, STATUS_OK},
			'{mk(psme_pkg::OP_STAGE_PARAM, 0, 15, 32'sh7FFF_FFFF), 1'b1, STATUS_OK},
			'{mk(psme_pkg::OP_STAGE_PARAM, 0, 0, 32'sh8000_0000), 1'b1, STATUS_OK},
			'{mk(4'd10, 0, 0, 5), 1'b1, STATUS_OK},
			'{mk(4'd11, 3000, 3, -5), 1'b1, STATUS_OK},
			'{mk(4'd12, 4095, 15, 32'sh7FFF_FFFF), 1'b1, STATUS_OK},
			'{mk(4'd13, 1, 1, 1), 1'b1, STATUS_OK},
			'{mk(4'd14, 2, 2, 2), 1'b1, STATUS_OK},
			'{mk(4'd15, 4095, 15, -1), 1'b1, STATUS_OK}
		};
		heavy_rows = '{
			'{mk(psme_pkg::OP_SET_PARAM, 0, 1, 32'sh0002_0000), 1'b0, STATUS_OK},
			'{mk(psme_pkg::OP_STAGE_PARAM, 0, 2, 32'sh0001_8000), 1'b0, STATUS_OK},
			'{mk(psme_pkg::OP_STAGE_PARAM, 0, 0, -32'sh0001_0000), 1'b0, STATUS_OK},
			'{mk(psme_pkg::OP_REBUILD, 0, 0, 0), 1'b0, STATUS_OK},
			'{mk(psme_pkg::OP_PROJECT, 0, 0, 0), 1'b0, STATUS_OK},
			'{mk(psme_pkg::OP_READ, 7, 0, 0), 1'b0, STATUS_OK},
			'{mk(psme_pkg::OP_SET_PARAM, 0, 3, 32'sh7FFF_FFFF), 1'b0, STATUS_OK},
			'{mk(psme_pkg::OP_TO_MEAN, 0, 0, 0), 1'b0, STATUS_OK},
			'{mk(psme_pkg::OP_READ, 100, 0, 0), 1'b0, STATUS_OK},
			'{mk(psme_pkg::OP_PROJECT, 0, 0, 0), 1'b0, STATUS_OK}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// long receiver hold-off while words keep coming
		hold_req = 1'b1;
		foreach (early_rows[r]) send_word(early_rows[r].it, early_rows[r].typed,
			early_rows[r].exp);
		drain_results();

		// fill every store before anything reads it whole
		for (int c = 0; c < psme_pkg::NUM_COMPONENTS; c++)
			send_word(mk(psme_pkg::OP_STDDEV, 0, c, (c == 3) ? 0 :
				((c == 5) ? -32'sh0001_4000 : int'($urandom_range(1 << 13, 1 << 17)))),
				1'b0, STATUS_OK);
		for (int i = 0; i < psme_pkg::NCOORD; i++) begin
			send_word(mk(psme_pkg::OP_MEAN, i, 0, data_word(1 << 20)), 1'b0, STATUS_OK);
			send_word(mk(psme_pkg::OP_COORD, i, 0, data_word(1 << 20)), 1'b0, STATUS_OK);
		end
		for (int c = 0; c < psme_pkg::NUM_COMPONENTS; c++)
			for (int i = 0; i < psme_pkg::NCOORD; i++)
				send_word(mk(psme_pkg::OP_BASIS, i, c, ($urandom_range(0, 511) == 0) ?
					int'($urandom) : small_word(1 << 16)), 1'b0, STATUS_OK);
		drain_results();

		foreach (heavy_rows[r]) send_word(heavy_rows[r].it, 1'b0, STATUS_OK);
		drain_results();

		for (int n = 0; n < 110; n++) begin
			psme_pkg::item_t it;
			if (n == 90) begin
				drain_results();
				quiet = 1'b1;
			end
			it = random_word(heavy < MAX_HEAVY);
			if (it.operation == psme_pkg::OP_REBUILD || it.operation == psme_pkg::OP_PROJECT)
				heavy++;
			send_word(it, 1'b0, STATUS_OK);
		end
		drain_results();
		repeat (50) @(posedge clk);

		if (mismatches == 0)
			$display("pca_shape_model_engine regression: pass");
		else
			$display("pca_shape_model_engine regression: fail");
		$finish;
	end

endmodule
